### rtl/pid_motor_position_control_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PID motor position controller
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PID_MOTOR_POSITION_CONTROL_MACROS_SVH
`define PID_MOTOR_POSITION_CONTROL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pmpc_pkg.sv
// ----------------------------------------------------------------------------
// PID motor position control package
// Shared types and fixed constants of the controller and its datapath.
// ----------------------------------------------------------------------------
package pmpc_pkg;

    localparam int GAIN_W     = 16;
    localparam int DT_W       = 16;
    localparam int MB_W       = 17;
    localparam int ISUM_W     = 48;
    localparam int ISPLIT     = 24;
    localparam int DIVD_W     = 18;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 2;

    // The command divisor 256000 is 2048 * 125. After the shift by 11, the
    // quotient by 125 is a multiply by 33555 and a shift by 22, which is exact
    // for every operand below 32000.
    localparam int          CMD_PRE_SHIFT   = 11;
    localparam int unsigned CMD_RECIP       = 33555;
    localparam int          CMD_RECIP_SHIFT = 22;
    localparam int unsigned CMD_LIMIT       = 65536000;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP  = 2'd0,
        CFG_INTEG = 2'd1,
        CFG_DERIV = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INTEG,
        S_PACC,
        S_ILO,
        S_IHI,
        S_WAIT_D,
        S_DMUL,
        S_DACC,
        S_SCALE,
        S_SUM,
        S_CLAMP,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_DT,
        MUL_PROP_ERR,
        MUL_INTEG_LO,
        MUL_INTEG_HI,
        MUL_DGAIN_DERIV,
        MUL_CMD_RECIP
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     prev_upd;
        t_mul_sel mul_sel;
        logic     sum_upd;
        logic     pd_load;
        logic     pd_add;
        logic     pd_scale;
        logic     acc_lo;
        logic     acc_hi;
        logic     acc_add_pd;
        logic     clamp;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/pid_motor_position_control.sv
// ----------------------------------------------------------------------------
// PID motor position control, top level
// One item at a time: the next input is taken only after the last result
// is loaded into the result register. The sequencer waits for the
// bit-serial divide by the elapsed time; a result held by a stall holds
// back the next result, and no new input is taken until that one is loaded.
// Synchronous reset clears the gains, the error history, the integral and
// the stillness count; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "pid_motor_position_control_macros.svh"

module pid_motor_position_control #(
    parameter int POS_BITS    = 24,
    parameter int STILL_LIMIT = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pmpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmpc_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [POS_BITS-1:0]     i_target_pos,
    input  logic signed [POS_BITS-1:0]     i_measured_pos,
    input  logic [pmpc_pkg::DT_W-1:0]      i_elapsed_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_dir_forward,
    output logic                           o_dir_reverse,
    output logic [pmpc_pkg::DUTY_W-1:0]    o_pwm_duty,
    output logic                           o_integral_cleared
);
    import pmpc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pmpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pmpc_dp #(
        .POS_BITS    (POS_BITS),
        .STILL_LIMIT (STILL_LIMIT)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_target_pos       (i_target_pos),
        .i_measured_pos     (i_measured_pos),
        .i_elapsed_ms       (i_elapsed_ms),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_dir_forward      (o_dir_forward),
        .o_dir_reverse      (o_dir_reverse),
        .o_pwm_duty         (o_pwm_duty),
        .o_integral_cleared (o_integral_cleared)
    );

    `PMPC_ASSERT_NOW(a_dir_exclusive, o_out_valid, o_dir_forward != o_dir_reverse, "direction bits not exclusive")
    `PMPC_ASSERT_NOW(a_fwd_duty, o_out_valid && o_dir_forward, o_pwm_duty != '0, "forward with zero duty")
    `PMPC_ASSERT_NEXT(a_busy_after_in, i_in_valid && !o_in_stall, o_in_stall, "input taken while busy")
    `PMPC_ASSERT_NOW(a_no_overwrite, w_cmd.out_load, !o_out_valid || !i_out_stall, "result overwritten")

endmodule

### rtl/pmpc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, busy while the quotient bits are formed.
// ----------------------------------------------------------------------------
module pmpc_div #(
    parameter int DIVN_W = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DIVN_W-1:0]           i_dividend,
    input  logic [pmpc_pkg::DIVD_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [DIVN_W-1:0]           o_quotient
);
    import pmpc_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_dvs;
    logic [DIVN_W-1:0] r_quo;

    logic [DIVD_W:0]   w_rem_sh;
    logic              w_ge;
    logic [DIVD_W:0]   w_diff;

    assign w_rem_sh = {r_rem, r_quo[DIVN_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVD_W-1:0] : w_rem_sh[DIVD_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### rtl/pmpc_dp.sv
// ----------------------------------------------------------------------------
// PID motor position control datapath
// Error, integral and derivative state, the shared multiplier, the divider,
// the gain registers and the result register.
// ----------------------------------------------------------------------------
module pmpc_dp #(
    parameter int POS_BITS    = 24,
    parameter int STILL_LIMIT = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmpc_pkg::t_dp_cmd              i_cmd,
    output pmpc_pkg::t_dp_sts              o_sts,
    input  logic                           i_cfg_valid,
    input  logic [pmpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmpc_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic signed [POS_BITS-1:0]     i_target_pos,
    input  logic signed [POS_BITS-1:0]     i_measured_pos,
    input  logic [pmpc_pkg::DT_W-1:0]      i_elapsed_ms,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_dir_forward,
    output logic                           o_dir_reverse,
    output logic [pmpc_pkg::DUTY_W-1:0]    o_pwm_duty,
    output logic                           o_integral_cleared
);
    import pmpc_pkg::*;

    localparam int ERR_W  = POS_BITS + 1;
    localparam int MA_W   = (POS_BITS + 2 > ISPLIT + 1) ? POS_BITS + 2 : ISPLIT + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUMX_W = ((ISUM_W > PROD_W) ? ISUM_W : PROD_W) + 1;
    localparam int PD_W   = PROD_W + 11;
    localparam int ACC_W  = ((GAIN_W + ISUM_W > PD_W) ? GAIN_W + ISUM_W : PD_W) + 2;
    localparam int DIVN_W = ERR_W;
    localparam int ST_W   = $clog2(STILL_LIMIT + 1);

    localparam logic signed [SUMX_W-1:0] SUM_MAX =
        {{(SUMX_W-ISUM_W+1){1'b0}}, {(ISUM_W-1){1'b1}}};
    localparam logic signed [SUMX_W-1:0] SUM_MIN =
        {{(SUMX_W-ISUM_W+1){1'b1}}, {(ISUM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(CMD_LIMIT);

    logic signed [GAIN_W-1:0] r_prop;
    logic signed [GAIN_W-1:0] r_integ;
    logic signed [GAIN_W-1:0] r_deriv;

    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_prev;
    logic [DT_W-1:0]          r_dt;
    logic                     r_dneg;
    logic signed [ISUM_W-1:0] r_sum;
    logic [ST_W-1:0]          r_still;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PD_W-1:0]   r_pd;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;
    logic                     r_neg;

    logic                     r_out_valid;
    logic                     r_dir_forward;
    logic [DUTY_W-1:0]        r_pwm_duty;
    logic                     r_cleared;

    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [ERR_W:0]    w_ediff;
    logic [ERR_W:0]           w_ediff_mag;
    logic signed [MA_W-1:0]   w_dval;
    logic signed [ACC_W-1:0]  w_acc_mag;
    logic signed [SUMX_W-1:0] n_sumx;
    logic signed [ISUM_W-1:0] n_sum;
    logic                     w_div_busy;
    logic [DIVN_W-1:0]        w_quo;
    logic [DIVN_W-1:0]        w_dividend;
    logic [DIVD_W-1:0]        w_divisor;
    logic                     w_sat;
    logic                     w_out_free;
    logic                     w_small;
    logic [ST_W-1:0]          n_still;
    logic                     w_clear;
    logic [DUTY_W-1:0]        w_duty;

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop  <= '0;
            r_integ <= '0;
            r_deriv <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP:  r_prop  <= $signed(i_cfg_data);
                CFG_INTEG: r_integ <= $signed(i_cfg_data);
                CFG_DERIV: r_deriv <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Derivative numerator and its magnitude.
    assign w_ediff     = (ERR_W+1)'(r_prev) - (ERR_W+1)'(r_err);
    assign w_ediff_mag = w_ediff[ERR_W] ? $unsigned(-w_ediff) : $unsigned(w_ediff);

    // A zero elapsed time gives a zero derivative.
    always_comb begin
        if (r_dt == '0) begin
            w_dval = '0;
        end else if (r_dneg) begin
            w_dval = -$signed(MA_W'(w_quo[ERR_W-1:0]));
        end else begin
            w_dval = $signed(MA_W'(w_quo[ERR_W-1:0]));
        end
    end

    assign w_acc_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_DT: begin
                w_ma = MA_W'(r_err);
                w_mb = $signed({1'b0, r_dt});
            end
            MUL_PROP_ERR: begin
                w_ma = MA_W'(r_err);
                w_mb = MB_W'(r_prop);
            end
            MUL_INTEG_LO: begin
                w_ma = $signed(MA_W'(r_sum[ISPLIT-1:0]));
                w_mb = MB_W'(r_integ);
            end
            MUL_INTEG_HI: begin
                w_ma = MA_W'($signed(r_sum[ISUM_W-1:ISPLIT]));
                w_mb = MB_W'(r_integ);
            end
            MUL_DGAIN_DERIV: begin
                w_ma = w_dval;
                w_mb = MB_W'(r_deriv);
            end
            MUL_CMD_RECIP: begin
                w_ma = MA_W'(w_acc_mag >> CMD_PRE_SHIFT);
                w_mb = $signed(MB_W'(CMD_RECIP));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Saturating integral update.
    always_comb begin
        n_sumx = SUMX_W'(r_sum) - SUMX_W'(r_prod);
        if (n_sumx > SUM_MAX) begin
            n_sum = SUM_MAX[ISUM_W-1:0];
        end else if (n_sumx < SUM_MIN) begin
            n_sum = SUM_MIN[ISUM_W-1:0];
        end else begin
            n_sum = n_sumx[ISUM_W-1:0];
        end
    end

    // The divider serves the derivative only.
    assign w_dividend = DIVN_W'(w_ediff_mag);
    assign w_divisor  = DIVD_W'(r_dt);

    pmpc_div #(
        .DIVN_W (DIVN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_sat = (r_acc >= ACC_LIM) || (r_acc <= -ACC_LIM);

    // Stillness counter and integral clear.
    assign w_small = (r_err >= -$signed(ERR_W'(1))) && (r_err <= $signed(ERR_W'(1)));

    always_comb begin
        if (!w_small) begin
            n_still = '0;
        end else if (r_still < ST_W'(STILL_LIMIT)) begin
            n_still = r_still + ST_W'(1);
        end else begin
            n_still = r_still;
        end
    end

    assign w_clear    = n_still >= ST_W'(STILL_LIMIT);
    assign w_duty     = r_sat ? DUTY_MAX : r_prod[CMD_RECIP_SHIFT +: DUTY_W];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sum   <= '0;
            r_still <= '0;
        end else begin
            if (i_cmd.prev_upd) begin
                r_prev <= r_err;
            end
            if (i_cmd.sum_upd) begin
                r_sum <= n_sum;
            end else if (i_cmd.out_load && w_clear) begin
                r_sum <= '0;
            end
            if (i_cmd.out_load) begin
                r_still <= n_still;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= ERR_W'(i_target_pos) - ERR_W'(i_measured_pos);
            r_dt  <= i_elapsed_ms;
        end
        if (i_cmd.prev_upd) begin
            r_dneg <= w_ediff[ERR_W];
        end
        if (i_cmd.pd_load) begin
            r_pd <= PD_W'(r_prod);
        end else if (i_cmd.pd_add) begin
            r_pd <= r_pd + PD_W'(r_prod);
        end else if (i_cmd.pd_scale) begin
            r_pd <= (r_pd <<< 10) - (r_pd <<< 4) - (r_pd <<< 3);
        end
        if (i_cmd.acc_lo) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_cmd.acc_hi) begin
            r_acc <= r_acc + (ACC_W'(r_prod) <<< ISPLIT);
        end else if (i_cmd.acc_add_pd) begin
            r_acc <= r_acc + ACC_W'(r_pd);
        end
        if (i_cmd.clamp) begin
            r_sat <= w_sat;
            r_neg <= r_acc[ACC_W-1];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_dir_forward <= !r_neg && (w_duty != '0);
            r_pwm_duty    <= w_duty;
            r_cleared     <= w_clear;
        end
    end

    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid        = r_out_valid;
    assign o_dir_forward      = r_dir_forward;
    assign o_dir_reverse      = !r_dir_forward;
    assign o_pwm_duty         = r_pwm_duty;
    assign o_integral_cleared = r_cleared;

endmodule

### rtl/pmpc_ctrl.sv
// ----------------------------------------------------------------------------
// PID motor position control sequencer
// Steps one item through the datapath and holds off input while busy.
// ----------------------------------------------------------------------------
module pmpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pmpc_pkg::t_dp_sts i_sts,
    output pmpc_pkg::t_dp_cmd o_cmd
);
    import pmpc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START:  n_state = S_INTEG;
            S_INTEG:  n_state = S_PACC;
            S_PACC:   n_state = S_ILO;
            S_ILO:    n_state = S_IHI;
            S_IHI:    n_state = S_WAIT_D;
            S_WAIT_D: begin
                if (!i_sts.div_busy) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL:   n_state = S_DACC;
            S_DACC:   n_state = S_SCALE;
            S_SCALE:  n_state = S_SUM;
            S_SUM:    n_state = S_CLAMP;
            S_CLAMP:  n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.prev_upd  = 1'b1;
                o_cmd.mul_sel   = MUL_ERR_DT;
            end
            S_INTEG: begin
                o_cmd.sum_upd = 1'b1;
                o_cmd.mul_sel = MUL_PROP_ERR;
            end
            S_PACC: begin
                o_cmd.pd_load = 1'b1;
                o_cmd.mul_sel = MUL_INTEG_LO;
            end
            S_ILO: begin
                o_cmd.acc_lo  = 1'b1;
                o_cmd.mul_sel = MUL_INTEG_HI;
            end
            S_IHI:    o_cmd.acc_hi = 1'b1;
            S_DMUL:   o_cmd.mul_sel = MUL_DGAIN_DERIV;
            S_DACC:   o_cmd.pd_add = 1'b1;
            S_SCALE:  o_cmd.pd_scale = 1'b1;
            S_SUM:    o_cmd.acc_add_pd = 1'b1;
            S_CLAMP: begin
                o_cmd.clamp   = 1'b1;
                o_cmd.mul_sel = MUL_CMD_RECIP;
            end
            S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.mul_sel  = MUL_CMD_RECIP;
            end
            default: begin
            end
        endcase
    end

endmodule

### verif/tb_pid_motor_position_control.sv
// ----------------------------------------------------------------------------
// Testbench for the PID motor position controller
// Drives control steps and gain writes, predicts the bridge direction, duty
// and integral clear of every step with its own model of the controller,
// and compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pid_motor_position_control;

    localparam int POS_W       = 24;
    localparam int STILL_MAX   = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DUTY_LIMIT  = 255;

    localparam longint ISUM_HI  = (longint'(1) <<< 47) - 1;
    localparam longint ISUM_LO  = -ISUM_HI - 1;
    localparam longint CMD_UNIT = 256000;

    localparam logic [pmpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
        logic       cleared;
    } drive_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pmpc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pmpc_pkg::GAIN_W-1:0]     i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic signed [POS_W-1:0]         i_target_pos = '0;
    logic signed [POS_W-1:0]         i_measured_pos = '0;
    logic [pmpc_pkg::DT_W-1:0]       i_elapsed_ms = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_dir_forward;
    logic                            o_dir_reverse;
    logic [pmpc_pkg::DUTY_W-1:0]     o_pwm_duty;
    logic                            o_integral_cleared;

    logic signed [15:0] kp_gain = '0;
    logic signed [15:0] ki_gain = '0;
    logic signed [15:0] kd_gain = '0;
    longint             last_err = 0;
    longint             integ_sum = 0;
    int                 still_run = 0;

    drive_t pending_drive[$];
    int     drive_errors = 0;
    int     cycle_count = 0;
    bit     in_gaps_on = 1'b1;
    bit     out_stalls_on = 1'b1;

    pid_motor_position_control #(
        .POS_BITS    (POS_W),
        .STILL_LIMIT (STILL_MAX)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_target_pos       (i_target_pos),
        .i_measured_pos     (i_measured_pos),
        .i_elapsed_ms       (i_elapsed_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_dir_forward      (o_dir_forward),
        .o_dir_reverse      (o_dir_reverse),
        .o_pwm_duty         (o_pwm_duty),
        .o_integral_cleared (o_integral_cleared)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= out_stalls_on && ($urandom_range(0, 99) < 32);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic drive_t predict_drive(input logic [POS_W-1:0] tgt,
                                             input logic [POS_W-1:0] meas,
                                             input logic [15:0] dt);
        longint err;
        longint span;
        longint rate;
        longint acc;
        longint cmd;
        drive_t r;
        err  = longint'($signed(tgt)) - longint'($signed(meas));
        span = longint'(dt);
        rate = 0;
        if (dt != 16'd0) begin
            rate = (last_err - err) / span;
        end
        integ_sum = integ_sum - err * span;
        if (integ_sum > ISUM_HI) begin
            integ_sum = ISUM_HI;
        end
        if (integ_sum < ISUM_LO) begin
            integ_sum = ISUM_LO;
        end
        last_err = err;
        acc = longint'(kp_gain) * err * 1000 + longint'(kd_gain) * rate * 1000
            + longint'(ki_gain) * integ_sum;
        cmd = acc / CMD_UNIT;
        if (cmd > DUTY_LIMIT) begin
            cmd = DUTY_LIMIT;
        end
        if (cmd < -DUTY_LIMIT) begin
            cmd = -DUTY_LIMIT;
        end
        if (err >= -1 && err <= 1) begin
            if (still_run < STILL_MAX) begin
                still_run++;
            end
        end else begin
            still_run = 0;
        end
        r.cleared = (still_run >= STILL_MAX);
        if (r.cleared) begin
            integ_sum = 0;
        end
        r.fwd  = (cmd > 0);
        r.rev  = !(cmd > 0);
        r.duty = 8'((cmd < 0) ? -cmd : cmd);
        return r;
    endfunction

    always @(posedge i_clk) begin : check_drive
        drive_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drive.size() == 0) begin
                $error("result transfer with no control step pending");
                drive_errors++;
            end else begin
                want = pending_drive.pop_front();
                if (o_dir_forward !== want.fwd) begin
                    $error("dir_forward: expected %0d, actual %0d", want.fwd, o_dir_forward);
                    drive_errors++;
                end
                if (o_dir_reverse !== want.rev) begin
                    $error("dir_reverse: expected %0d, actual %0d", want.rev, o_dir_reverse);
                    drive_errors++;
                end
                if (o_pwm_duty !== want.duty) begin
                    $error("pwm_duty: expected %0d, actual %0d", want.duty, o_pwm_duty);
                    drive_errors++;
                end
                if (o_integral_cleared !== want.cleared) begin
                    $error("integral_cleared: expected %0d, actual %0d",
                           want.cleared, o_integral_cleared);
                    drive_errors++;
                end
            end
        end
    end

    task automatic send_step(input logic [POS_W-1:0] tgt, input logic [POS_W-1:0] meas,
                             input logic [15:0] dt);
        while (in_gaps_on && $urandom_range(0, 99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_target_pos   <= tgt;
        i_measured_pos <= meas;
        i_elapsed_ms   <= dt;
        do @(posedge i_clk); while (o_in_stall);
        pending_drive.push_back(predict_drive(tgt, meas, dt));
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the three gains in order, then a write to the unused index,
    // which the controller has to ignore.
    task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd);
        logic [pmpc_pkg::CFG_IDX_W-1:0] idx [4];
        logic [15:0]                    val [4];
        idx[0] = pmpc_pkg::CFG_PROP;
        idx[1] = pmpc_pkg::CFG_INTEG;
        idx[2] = pmpc_pkg::CFG_DERIV;
        idx[3] = CFG_SPARE;
        val[0] = kp;
        val[1] = ki;
        val[2] = kd;
        val[3] = 16'($urandom);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                pmpc_pkg::CFG_PROP:  kp_gain = val[k];
                pmpc_pkg::CFG_INTEG: ki_gain = val[k];
                pmpc_pkg::CFG_DERIV: kd_gain = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 511) - 256);
            3:       return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_elapsed();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 8));
            2:       return 16'($urandom_range(1, 200));
            3:       return 16'(65535 - $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_state();
        send_step(24'd0, 24'd0, 16'd1);
        send_step(24'd5000, 24'd0, 16'd100);
        wait_results_done();
    endtask

    task automatic test_directed_commands();
        load_gains(16'h0100, 16'h0000, 16'h0000);
        send_step(24'd100, 24'd0, 16'd1);
        send_step(24'd0, 24'd100, 16'd1);
        send_step(24'd1000, 24'd700, 16'd5);
        wait_results_done();
        load_gains(16'h7FFF, 16'h8000, 16'h7FFF);
        send_step(24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_step(24'h800000, 24'h7FFFFF, 16'd1);
        wait_results_done();
        load_gains(16'h8000, 16'h7FFF, 16'h8000);
        send_step(24'h7FFFFF, 24'h800000, 16'd0);
        wait_results_done();
        load_gains(16'h0000, 16'h0000, 16'h0100);
        send_step(24'd0, 24'd0, 16'd1);
        send_step(24'd500, 24'd0, 16'd0);
        send_step(24'd0, 24'd0, 16'd7);
        send_step(24'd0, 24'd1000, 16'd3);
        send_step(24'd0, -24'sd10, 16'hFFFF);
        send_step(24'd0, 24'd0, 16'd1);
        send_step(24'd7, 24'd0, 16'd2);
        wait_results_done();
    endtask

    // The first still run wipes whatever the integral holds, so the small
    // integral commands after it are known exactly.
    task automatic test_stillness_clear();
        logic [POS_W-1:0] base;
        wait_results_done();
        load_gains(16'h0000, 16'h0100, 16'h0000);
        for (int k = 0; k < STILL_MAX + 1; k++) begin
            base = 24'($urandom);
            send_step(base + 24'(k % 3) - 24'd1, base, 16'd10);
        end
        send_step(24'd0, 24'd10, 16'd1000);
        send_step(24'd0, 24'd50, 16'd100);
        for (int k = 0; k < STILL_MAX + 1; k++) begin
            send_step(24'(k % 3) - 24'd1, 24'd0, 16'd10);
        end
        send_step(24'd0, 24'd9, 16'd10);
        send_step(24'd3, 24'd3, 16'd1);
        wait_results_done();
    endtask

    // Drives the integral into saturation at both ends, with no idling on
    // either side. After each saturation, steps with no elapsed time ask for
    // an error that nearly cancels the saturated integral term, so the duty
    // depends on the exact saturated value.
    task automatic test_integral_windup();
        int     guard;
        int     jitter;
        longint aim;
        wait_results_done();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        load_gains(16'h8000, 16'h0001, 16'h0000);
        for (int side = 0; side < 2; side++) begin
            guard = 0;
            while (integ_sum != ((side == 0) ? ISUM_HI : ISUM_LO) && guard < 300) begin
                jitter = $urandom_range(0, 255);
                if (side == 0) begin
                    send_step(24'h800000 + 24'(jitter), 24'h7FFFFF - 24'(jitter),
                              16'(65535 - $urandom_range(0, 255)));
                end else begin
                    send_step(24'h7FFFFF - 24'(jitter), 24'h800000 + 24'(jitter),
                              16'(65535 - $urandom_range(0, 255)));
                end
                guard++;
            end
            repeat (3) begin
                send_step(24'h800000, 24'h7FFFFF, 16'hFFFF);
            end
            for (int k = 0; k < 6; k++) begin
                aim = integ_sum / 32768000 + longint'(int'($urandom_range(0, 2)) - 1);
                send_step(24'(aim), 24'd0, 16'd0);
            end
            for (int k = 0; k < STILL_MAX; k++) begin
                send_step(24'd0, 24'd0, 16'd1);
            end
        end
        wait_results_done();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    task automatic test_random_steps(input int phases, input int per_phase);
        int               sent;
        int               run_len;
        int               mode;
        int               err;
        logic [POS_W-1:0] meas;
        for (int p = 0; p < phases; p++) begin
            wait_results_done();
            load_gains(rand_gain(), rand_gain(), rand_gain());
            sent = 0;
            while (sent < per_phase) begin
                mode    = $urandom_range(0, 3);
                run_len = (mode == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
                repeat (run_len) begin
                    meas = 24'($urandom);
                    case (mode)
                        0: begin
                            err = int'($urandom_range(0, 2)) - 1;
                            send_step(meas + 24'(err), meas, rand_elapsed());
                        end
                        1: begin
                            err = int'($urandom_range(0, 8000)) - 4000;
                            send_step(meas + 24'(err), meas, rand_elapsed());
                        end
                        2: send_step(24'($urandom), meas, rand_elapsed());
                        default: begin
                            err = int'($urandom_range(0, 120)) - 60;
                            send_step(meas + 24'(err), meas, 16'($urandom_range(1, 4)));
                        end
                    endcase
                end
                sent += run_len;
                if ($urandom_range(0, 4) == 0) begin
                    wait_results_done();
                end
            end
        end
        wait_results_done();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_commands();
        test_stillness_clear();
        test_integral_windup();
        test_random_steps(3, 25);
        wait_results_done();
        repeat (80) @(posedge i_clk);
        if (drive_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### pid_motor_position_control.f
+incdir+rtl
rtl/pmpc_pkg.sv
rtl/pmpc_div.sv
rtl/pmpc_dp.sv
rtl/pmpc_ctrl.sv
rtl/pid_motor_position_control.sv
verif/tb_pid_motor_position_control.sv
